// ===== sv/tdma_slot_map_with_candidate_pick_top_macros.svh =====
// Assertion macros for the TDMA slot map block.
// Used by the datapath; expects aclk and aresetn in scope.
`ifndef TDMA_SLOT_MAP_WITH_CANDIDATE_PICK_TOP_MACROS_SVH
`define TDMA_SLOT_MAP_WITH_CANDIDATE_PICK_TOP_MACROS_SVH

// Condition holds at every clock edge out of reset
`define TSMAP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define TSMAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tsmap_pkg.sv =====
// Shared types and constants of the TDMA slot map block.
// No dependencies; used by every module of the block.
package tsmap_pkg;

    // Default parameter values
    localparam int RING_FRAMES_DEF     = 4;
    localparam int SLOTS_PER_FRAME_DEF = 2250;
    localparam int CANDIDATE_DEPTH_DEF = 255;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int FRAME_W = 31;
    localparam int CH_W    = 2;
    localparam int SLOTF_W = 12;
    localparam int STATE_W = 4;
    localparam int SEL_W   = 12;
    localparam int RND_W   = 16;
    localparam int CNTF_W  = 8;

    // Port widths
    localparam int S_TDATA_W   = 112;
    localparam int S_TUSER_W   = FUNC_W;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    // Input tdata field offsets
    localparam int OFS_CUR  = 0;
    localparam int OFS_CH   = 31;
    localparam int OFS_SLOT = 33;
    localparam int OFS_TF   = 45;
    localparam int OFS_NST  = 76;
    localparam int OFS_SEL  = 80;
    localparam int OFS_BOTH = 92;
    localparam int OFS_RND  = 93;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_GET     = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_PICK    = 2'd3;

    // Channel codes
    localparam logic [CH_W-1:0] CH_A = 2'd0;
    localparam logic [CH_W-1:0] CH_B = 2'd1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CEIL  = 1'b1;
    localparam logic [CFG_DATA_W-1:0]  FLOOR_RST = 7'd1;
    localparam logic [CFG_DATA_W-1:0]  CEIL_RST  = 7'd127;

    // Slot byte nibble masks
    localparam logic [7:0] MASK_A = 8'h0F;
    localparam logic [7:0] MASK_B = 8'hF0;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic adv;
        logic clr_step;
        logic smod_start;
        logic smod_take;
        logic op_issue;
        logic rmw;
        logic probe;
        logic check;
        logic rmod_start;
        logic cand_take;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              need_clr;
        logic              clr_last;
        logic              div_done;
        logic              pick_ok;
        logic              probe_last;
        logic              cnt_zero;
        logic              out_free;
    } sts_t;

endpackage

// ===== sv/tsmap_div.sv =====
// Iterative remainder unit, one dividend bit per cycle.
// Depends on tsmap_pkg.
module tsmap_div #(
    parameter int DIV_W = 13
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tsmap_pkg::RND_W-1:0] dividend,
    input  logic [DIV_W-1:0]           divisor,
    output logic                       done,
    output logic [DIV_W-1:0]           rem
);
    import tsmap_pkg::*;

    localparam int STEP_W = $clog2(RND_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [RND_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  dvs_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic [DIV_W-1:0]  rem_next;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        trial = {rem_reg, dvd_reg[RND_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        rem_next = (trial >= {1'b0, dvs_reg}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                dvd_reg  <= {dvd_reg[RND_W-2:0], 1'b0};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(RND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== sv/tsmap_ctrl.sv =====
// Controller state machine of the TDMA slot map block.
// Depends on tsmap_pkg; drives the datapath through cmd_t.
module tsmap_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tsmap_pkg::sts_t   sts,
    output tsmap_pkg::cmd_t   cmd
);
    import tsmap_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ADV, S_CLEAR, S_SMOD, S_SWAIT, S_OP, S_RMW,
        S_PROBE, S_CHECK, S_RMOD, S_RWAIT, S_CTAKE, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_ADV;
                end
            end
            S_ADV: begin
                cmd.adv    = 1'b1;
                state_next = sts.need_clr ? S_CLEAR : S_SMOD;
            end
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = S_SMOD;
            end
            S_SMOD: begin
                cmd.smod_start = 1'b1;
                state_next     = S_SWAIT;
            end
            S_SWAIT: begin
                if (sts.div_done) begin
                    cmd.smod_take = 1'b1;
                    state_next    = S_OP;
                end
            end
            S_OP: begin
                cmd.op_issue = 1'b1;
                unique case (sts.func) inside
                    FUNC_SET, FUNC_GET: state_next = S_RMW;
                    FUNC_PICK:          state_next = sts.pick_ok ? S_PROBE : S_DONE;
                    default:            state_next = S_DONE;
                endcase
            end
            S_RMW: begin
                cmd.rmw    = 1'b1;
                state_next = S_DONE;
            end
            S_PROBE: begin
                cmd.probe  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.probe_last ? S_RMOD : S_PROBE;
            end
            S_RMOD: begin
                if (sts.cnt_zero) begin
                    state_next = S_DONE;
                end else begin
                    cmd.rmod_start = 1'b1;
                    state_next     = S_RWAIT;
                end
            end
            S_RWAIT: begin
                if (sts.div_done) state_next = S_CTAKE;
            end
            S_CTAKE: begin
                cmd.cand_take = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    // Hold state and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

endmodule

// ===== sv/tsmap_dp.sv =====
// Datapath of the TDMA slot map block: ring state, slot table, candidates.
// Depends on tsmap_pkg, tsmap_div and the assertion macro header.
`include "tdma_slot_map_with_candidate_pick_top_macros.svh"
module tsmap_dp #(
    parameter int RING_FRAMES     = 4,
    parameter int SLOTS_PER_FRAME = 2250,
    parameter int CANDIDATE_DEPTH = 255
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [tsmap_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [tsmap_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                              cfg_wr_en,
    input  logic [tsmap_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tsmap_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  tsmap_pkg::cmd_t                   cmd,
    output tsmap_pkg::sts_t                   sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tsmap_pkg::M_TDATA_W-1:0]   m_tdata
);
    import tsmap_pkg::*;

    localparam int ROW_W  = $clog2(RING_FRAMES);
    localparam int HW     = ROW_W + 1;
    localparam int SLOT_W = $clog2(SLOTS_PER_FRAME);
    localparam int TBL_N  = RING_FRAMES * SLOTS_PER_FRAME;
    localparam int ADDR_W = $clog2(TBL_N);
    localparam int CNT_W  = $clog2(CANDIDATE_DEPTH + 1);
    localparam int CIDX_W = $clog2(CANDIDATE_DEPTH);
    localparam int DIV_W  = $clog2(CANDIDATE_DEPTH + 1);

    // Slot reduction by reciprocal multiplication, exact for 12-bit slots
    localparam int SMOD_SH    = 24;
    localparam int SMOD_PW    = SLOTF_W + 25;
    localparam int SMOD_RECIP = ((1 << SMOD_SH) + SLOTS_PER_FRAME - 1) / SLOTS_PER_FRAME;

    typedef enum logic [1:0] {SIDE_CENTRE, SIDE_LEFT, SIDE_RIGHT} side_t;

    // Map a window offset to a ring row
    function automatic logic [ROW_W-1:0] row_of(input logic [ROW_W-1:0] h,
                                                 input logic [ROW_W-1:0] dl);
        logic [HW-1:0] s;
        s = {1'b0, h} + {1'b0, dl};
        if (s >= HW'(RING_FRAMES)) s = s - HW'(RING_FRAMES);
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                   input logic [SLOT_W-1:0] p);
        return ADDR_W'(r) * ADDR_W'(SLOTS_PER_FRAME) + ADDR_W'(p);
    endfunction

    // Captured item
    logic [FUNC_W-1:0]  func_reg;
    logic [FRAME_W-1:0] cur_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [SLOTF_W-1:0] slot_in_reg;
    logic [FRAME_W-1:0] tf_reg;
    logic [STATE_W-1:0] nst_reg;
    logic [SEL_W-1:0]   sel_reg;
    logic               both_reg;
    logic [RND_W-1:0]   rnd_reg;

    // Ring and configuration state
    logic [ROW_W-1:0]      ring_head_reg;
    logic [FRAME_W-1:0]    head_frame_reg;
    logic                  head_known_reg;
    logic                  pick_ok_reg;
    logic [CFG_DATA_W-1:0] floor_reg, ceil_reg;

    // Clearing sweep
    logic [ROW_W-1:0]  clr_row_reg;
    logic [SLOT_W-1:0] clr_slot_reg;
    logic [HW-1:0]     clr_left_reg;

    // Slot reduction
    logic [SLOTF_W-1:0] smod_q_reg;
    logic               smod_done_reg;

    // Operation and pick state
    logic [SLOT_W-1:0]     slot_reg;
    logic                  op_hit_reg;
    logic [ADDR_W-1:0]     op_addr_reg;
    logic [CFG_DATA_W-1:0] sel_eff_reg, step_reg;
    side_t                 side_reg;
    logic [SLOT_W-1:0]     lpos_reg, rpos_reg, probe_pos_reg;
    logic                  lwrap_reg, rwrap_reg, probe_hit_reg;
    logic [CNT_W-1:0]      cand_cnt_reg;

    // Result and output registers
    logic                  res_ok_reg;
    logic [STATE_W-1:0]    res_rs_reg;
    logic [SLOT_W-1:0]     res_chosen_reg;
    logic [CNT_W-1:0]      res_cnt_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    // Memories
    logic [7:0]        tbl_mem [TBL_N];
    logic [7:0]        tbl_rdata_reg;
    logic [SLOT_W-1:0] cand_mem [CANDIDATE_DEPTH];
    logic [SLOT_W-1:0] cand_rdata_reg;

    // Combinational datapath
    logic                  ch_ok;
    logic [31:0]           off_w, d_old, d_op;
    logic                  adv_pos;
    logic [HW-1:0]         adv_n, head_sum;
    logic                  op_hit;
    logic [ADDR_W-1:0]     op_addr;
    logic [CFG_DATA_W-1:0] sel_clamp;
    logic [SLOT_W-1:0]     probe_pos;
    logic                  probe_wrap;
    logic [32:0]           fd, d_pr;
    logic                  probe_hit;
    logic [ADDR_W-1:0]     probe_addr;
    logic [ADDR_W-1:0]     tbl_raddr;
    logic [STATE_W-1:0]    nib;
    logic [7:0]            merged;
    logic [SMOD_PW-1:0]    smod_prod;
    logic [2*SLOTF_W-1:0]  smod_qm;
    logic [SLOTF_W-1:0]    smod_rem;
    logic                  div_start, div_done;
    logic [RND_W-1:0]      div_dvd;
    logic [DIV_W-1:0]      div_dvs, div_rem;

    always_comb begin
        ch_ok = (ch_reg == CH_A) || (ch_reg == CH_B);

        // Advance: frames passed since the head, capped at the ring size
        off_w   = {1'b0, cur_reg} - {1'b0, head_frame_reg};
        adv_pos = !off_w[31] && (off_w != 32'd0);
        adv_n   = (off_w > 32'(RING_FRAMES)) ? HW'(RING_FRAMES) : off_w[HW-1:0];
        head_sum = {1'b0, ring_head_reg} + adv_n;
        if (head_sum >= HW'(RING_FRAMES)) head_sum = head_sum - HW'(RING_FRAMES);

        // Pick window against the head before the advance
        d_old = {1'b0, tf_reg} - {1'b0, head_frame_reg};

        // Set and get window against the current head
        d_op    = {1'b0, tf_reg} - {1'b0, head_frame_reg};
        op_hit  = !d_op[31] && (d_op < 32'(RING_FRAMES)) && ch_ok;
        op_addr = addr_of(row_of(ring_head_reg, d_op[ROW_W-1:0]), slot_reg);

        // Clamp the one-sided interval
        if (sel_reg < SEL_W'(floor_reg))     sel_clamp = floor_reg;
        else if (sel_reg > SEL_W'(ceil_reg)) sel_clamp = ceil_reg;
        else                                 sel_clamp = sel_reg[CFG_DATA_W-1:0];

        // Next probe position, wrapping into the neighbor frame
        probe_pos  = slot_reg;
        probe_wrap = 1'b0;
        fd         = 33'd0;
        unique case (side_reg)
            SIDE_LEFT: begin
                probe_pos  = (lpos_reg == '0) ? SLOT_W'(SLOTS_PER_FRAME - 1)
                                              : lpos_reg - 1'b1;
                probe_wrap = lwrap_reg || (lpos_reg == '0);
                fd         = probe_wrap ? '1 : 33'd0;
            end
            SIDE_RIGHT: begin
                probe_pos  = (rpos_reg == SLOT_W'(SLOTS_PER_FRAME - 1)) ? '0
                                                                       : rpos_reg + 1'b1;
                probe_wrap = rwrap_reg || (rpos_reg == SLOT_W'(SLOTS_PER_FRAME - 1));
                fd         = probe_wrap ? 33'd1 : 33'd0;
            end
            default: begin
                probe_pos  = slot_reg;
                probe_wrap = 1'b0;
                fd         = 33'd0;
            end
        endcase
        d_pr       = {2'b0, tf_reg} - {2'b0, head_frame_reg} + fd;
        probe_hit  = !d_pr[32] && (d_pr < 33'(RING_FRAMES));
        probe_addr = addr_of(row_of(ring_head_reg, d_pr[ROW_W-1:0]), probe_pos);

        tbl_raddr = cmd.probe ? probe_addr : op_addr;

        nib    = (ch_reg == CH_B) ? tbl_rdata_reg[7:4] : tbl_rdata_reg[3:0];
        merged = (ch_reg == CH_B) ? ((tbl_rdata_reg & MASK_A) | ({nst_reg, 4'b0} & MASK_B))
                                  : ((tbl_rdata_reg & MASK_B) | ({4'b0, nst_reg} & MASK_A));

        // Slot reduction: quotient by reciprocal, remainder from the held quotient
        smod_prod = SMOD_PW'(slot_in_reg) * SMOD_PW'(SMOD_RECIP);
        smod_qm   = (2*SLOTF_W)'(smod_q_reg) * (2*SLOTF_W)'(SLOTS_PER_FRAME);
        smod_rem  = slot_in_reg - smod_qm[SLOTF_W-1:0];

        // Remainder unit operands for the random pick
        div_start = cmd.rmod_start;
        div_dvd   = rnd_reg;
        div_dvs   = DIV_W'(cand_cnt_reg);
    end

    tsmap_div #(.DIV_W(DIV_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Slot table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            tbl_mem[addr_of(clr_row_reg, clr_slot_reg)] <= 8'h00;
        end else if (cmd.rmw && op_hit_reg && (func_reg == FUNC_SET)) begin
            tbl_mem[op_addr_reg] <= merged;
        end
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    // Candidate list
    always_ff @(posedge aclk) begin
        if (cmd.check && probe_hit_reg && (nib == '0)
            && (cand_cnt_reg < CNT_W'(CANDIDATE_DEPTH))) begin
            cand_mem[cand_cnt_reg[CIDX_W-1:0]] <= probe_pos_reg;
        end
        cand_rdata_reg <= cand_mem[div_rem[CIDX_W-1:0]];
    end

    // Control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_head_reg  <= '0;
            head_frame_reg <= '0;
            head_known_reg <= 1'b0;
            floor_reg      <= FLOOR_RST;
            ceil_reg       <= CEIL_RST;
            clr_row_reg    <= '0;
            clr_slot_reg   <= '0;
            clr_left_reg   <= HW'(RING_FRAMES);
            cand_cnt_reg   <= '0;
            smod_done_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FLOOR: floor_reg <= cfg_wr_data;
                    CFG_CEIL:  ceil_reg  <= cfg_wr_data;
                    default:   ;
                endcase
            end

            if (cmd.load_in) begin
                func_reg    <= s_tuser;
                cur_reg     <= s_tdata[OFS_CUR +: FRAME_W];
                ch_reg      <= s_tdata[OFS_CH +: CH_W];
                slot_in_reg <= s_tdata[OFS_SLOT +: SLOTF_W];
                tf_reg      <= s_tdata[OFS_TF +: FRAME_W];
                nst_reg     <= s_tdata[OFS_NST +: STATE_W];
                sel_reg     <= s_tdata[OFS_SEL +: SEL_W];
                both_reg    <= s_tdata[OFS_BOTH];
                rnd_reg     <= s_tdata[OFS_RND +: RND_W];
            end

            // Advance the ring; latch pick window on the old head
            if (cmd.adv) begin
                pick_ok_reg <= head_known_reg && !d_old[31]
                               && (d_old < 32'(RING_FRAMES)) && ch_ok;
                if (!head_known_reg) begin
                    head_frame_reg <= cur_reg;
                    head_known_reg <= 1'b1;
                end else if (adv_pos) begin
                    clr_row_reg    <= ring_head_reg;
                    clr_slot_reg   <= '0;
                    clr_left_reg   <= adv_n;
                    ring_head_reg  <= head_sum[ROW_W-1:0];
                    head_frame_reg <= cur_reg;
                end
            end

            // Sweep rows to free
            if (cmd.clr_step) begin
                if (clr_slot_reg == SLOT_W'(SLOTS_PER_FRAME - 1)) begin
                    clr_slot_reg <= '0;
                    clr_row_reg  <= (clr_row_reg == ROW_W'(RING_FRAMES - 1)) ? '0
                                                                             : clr_row_reg + 1'b1;
                    clr_left_reg <= clr_left_reg - 1'b1;
                end else begin
                    clr_slot_reg <= clr_slot_reg + 1'b1;
                end
            end

            // Hold the slot quotient; the remainder is ready next cycle
            smod_done_reg <= cmd.smod_start;
            if (cmd.smod_start) smod_q_reg <= smod_prod[SMOD_SH +: SLOTF_W];

            if (cmd.smod_take) slot_reg <= smod_rem[SLOT_W-1:0];

            // Start the operation and clear the result
            if (cmd.op_issue) begin
                op_hit_reg     <= op_hit;
                op_addr_reg    <= op_addr;
                res_ok_reg     <= (func_reg == FUNC_ADVANCE);
                res_rs_reg     <= '0;
                res_chosen_reg <= '0;
                res_cnt_reg    <= '0;
                sel_eff_reg    <= sel_clamp;
                step_reg       <= '0;
                side_reg       <= SIDE_CENTRE;
                lpos_reg       <= slot_reg;
                rpos_reg       <= slot_reg;
                lwrap_reg      <= 1'b0;
                rwrap_reg      <= 1'b0;
                cand_cnt_reg   <= '0;
            end

            if (cmd.rmw && op_hit_reg) begin
                res_ok_reg <= 1'b1;
                if (func_reg == FUNC_GET) res_rs_reg <= nib;
            end

            // Look up one candidate position
            if (cmd.probe) begin
                probe_pos_reg <= probe_pos;
                probe_hit_reg <= probe_hit;
                if (side_reg == SIDE_LEFT) begin
                    lpos_reg  <= probe_pos;
                    lwrap_reg <= probe_wrap;
                end
                if (side_reg == SIDE_RIGHT) begin
                    rpos_reg  <= probe_pos;
                    rwrap_reg <= probe_wrap;
                end
            end

            // Collect a free slot and step the search order
            if (cmd.check) begin
                if (probe_hit_reg && (nib == '0)
                    && (cand_cnt_reg < CNT_W'(CANDIDATE_DEPTH))) begin
                    cand_cnt_reg <= cand_cnt_reg + 1'b1;
                end
                case (side_reg)
                    SIDE_CENTRE: begin
                        step_reg <= CFG_DATA_W'(1);
                        side_reg <= both_reg ? SIDE_LEFT : SIDE_RIGHT;
                    end
                    SIDE_LEFT: side_reg <= SIDE_RIGHT;
                    default: begin
                        step_reg <= step_reg + 1'b1;
                        side_reg <= both_reg ? SIDE_LEFT : SIDE_RIGHT;
                    end
                endcase
            end

            if (cmd.cand_take) begin
                res_ok_reg     <= 1'b1;
                res_chosen_reg <= cand_rdata_reg;
                res_cnt_reg    <= cand_cnt_reg;
            end

            // Output register
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {7'b0, CNTF_W'(res_cnt_reg), SLOTF_W'(res_chosen_reg),
                                 res_rs_reg, res_ok_reg};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.func       = func_reg;
        sts.need_clr   = head_known_reg && adv_pos;
        sts.clr_last   = (clr_slot_reg == SLOT_W'(SLOTS_PER_FRAME - 1))
                         && (clr_left_reg == HW'(1));
        sts.div_done   = div_done || smod_done_reg;
        sts.pick_ok    = pick_ok_reg;
        sts.probe_last = ((side_reg == SIDE_CENTRE) && (sel_eff_reg == '0))
                         || ((side_reg == SIDE_RIGHT) && (step_reg == sel_eff_reg));
        sts.cnt_zero   = (cand_cnt_reg == '0);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TSMAP_ASSERT_ALWAYS(a_head_in_ring, {1'b0, ring_head_reg} < HW'(RING_FRAMES), "ring head out of range")
    `TSMAP_ASSERT_ALWAYS(a_cand_bound, cand_cnt_reg <= CNT_W'(CANDIDATE_DEPTH), "candidate count overflow")
    `TSMAP_ASSERT_NEXT(a_out_loaded, cmd.load_out, m_tvalid_reg, "result not presented after load")

endmodule

// ===== sv/tdma_slot_map_with_candidate_pick_top.sv =====
// TDMA slot map with candidate pick, top level. Depends on tsmap_pkg, tsmap_ctrl, tsmap_dp.
// One item at a time. Advance, with row clearing of min(passed frames, RING_FRAMES) rows;
// slot reduction; then set/get, or a pick of up to 1 + 2 * interval probes plus the random
// remainder and list read. The result is held in the output register. Reset (synchronous,
// aresetn low) clears the ring state, then a pass over all RING_FRAMES*SLOTS_PER_FRAME
// table entries frees the table.
module tdma_slot_map_with_candidate_pick_top #(
    parameter int RING_FRAMES     = tsmap_pkg::RING_FRAMES_DEF,
    parameter int SLOTS_PER_FRAME = tsmap_pkg::SLOTS_PER_FRAME_DEF,
    parameter int CANDIDATE_DEPTH = tsmap_pkg::CANDIDATE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // current_frame, channel, slot_number, target_frame, new_state,
    // select_interval, both_sides, random_value
    input  logic [tsmap_pkg::S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [tsmap_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ok, read_state, chosen_slot, candidate_count
    output logic [tsmap_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [tsmap_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tsmap_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import tsmap_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tsmap_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsmap_dp #(
        .RING_FRAMES     (RING_FRAMES),
        .SLOTS_PER_FRAME (SLOTS_PER_FRAME),
        .CANDIDATE_DEPTH (CANDIDATE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
